[hdl/md5_pkg.sv]
// Shared types, constants and round tables of the MD5 digest engine.
package md5_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } md5_in_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } md5_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_words_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } md5_state_e;

  localparam md5_words_t MD5_IV = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Message word used by a given round.
  function automatic logic [3:0] md5_msg_index(input logic [5:0] rnd);
    logic [3:0] idx;
    logic [3:0] res;
    idx = rnd[3:0];
    case (rnd[5:4])
      2'd0:    res = idx;
      2'd1:    res = 4'(idx * 4'd5 + 4'd1);
      2'd2:    res = 4'(idx * 4'd3 + 4'd5);
      default: res = 4'(idx * 4'd7);
    endcase
    return res;
  endfunction

  // Left-rotate amount of a round.
  function automatic logic [4:0] md5_shift(input logic [5:0] rnd);
    logic [4:0] res;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:    res = 5'd7;
      4'd1:    res = 5'd12;
      4'd2:    res = 5'd17;
      4'd3:    res = 5'd22;
      4'd4:    res = 5'd5;
      4'd5:    res = 5'd9;
      4'd6:    res = 5'd14;
      4'd7:    res = 5'd20;
      4'd8:    res = 5'd4;
      4'd9:    res = 5'd11;
      4'd10:   res = 5'd16;
      4'd11:   res = 5'd23;
      4'd12:   res = 5'd6;
      4'd13:   res = 5'd10;
      4'd14:   res = 5'd15;
      default: res = 5'd21;
    endcase
    return res;
  endfunction

  // Additive round constant, floor(abs(sin(i + 1)) * 2^32).
  function automatic logic [31:0] md5_k(input logic [5:0] rnd);
    logic [31:0] res;
    case (rnd)
      6'd0:  res = 32'hd76aa478;  6'd1:  res = 32'he8c7b756;
      6'd2:  res = 32'h242070db;  6'd3:  res = 32'hc1bdceee;
      6'd4:  res = 32'hf57c0faf;  6'd5:  res = 32'h4787c62a;
      6'd6:  res = 32'ha8304613;  6'd7:  res = 32'hfd469501;
      6'd8:  res = 32'h698098d8;  6'd9:  res = 32'h8b44f7af;
      6'd10: res = 32'hffff5bb1;  6'd11: res = 32'h895cd7be;
      6'd12: res = 32'h6b901122;  6'd13: res = 32'hfd987193;
      6'd14: res = 32'ha679438e;  6'd15: res = 32'h49b40821;
      6'd16: res = 32'hf61e2562;  6'd17: res = 32'hc040b340;
      6'd18: res = 32'h265e5a51;  6'd19: res = 32'he9b6c7aa;
      6'd20: res = 32'hd62f105d;  6'd21: res = 32'h02441453;
      6'd22: res = 32'hd8a1e681;  6'd23: res = 32'he7d3fbc8;
      6'd24: res = 32'h21e1cde6;  6'd25: res = 32'hc33707d6;
      6'd26: res = 32'hf4d50d87;  6'd27: res = 32'h455a14ed;
      6'd28: res = 32'ha9e3e905;  6'd29: res = 32'hfcefa3f8;
      6'd30: res = 32'h676f02d9;  6'd31: res = 32'h8d2a4c8a;
      6'd32: res = 32'hfffa3942;  6'd33: res = 32'h8771f681;
      6'd34: res = 32'h6d9d6122;  6'd35: res = 32'hfde5380c;
      6'd36: res = 32'ha4beea44;  6'd37: res = 32'h4bdecfa9;
      6'd38: res = 32'hf6bb4b60;  6'd39: res = 32'hbebfbc70;
      6'd40: res = 32'h289b7ec6;  6'd41: res = 32'heaa127fa;
      6'd42: res = 32'hd4ef3085;  6'd43: res = 32'h04881d05;
      6'd44: res = 32'hd9d4d039;  6'd45: res = 32'he6db99e5;
      6'd46: res = 32'h1fa27cf8;  6'd47: res = 32'hc4ac5665;
      6'd48: res = 32'hf4292244;  6'd49: res = 32'h432aff97;
      6'd50: res = 32'hab9423a7;  6'd51: res = 32'hfc93a039;
      6'd52: res = 32'h655b59c3;  6'd53: res = 32'h8f0ccc92;
      6'd54: res = 32'hffeff47d;  6'd55: res = 32'h85845dd1;
      6'd56: res = 32'h6fa87e4f;  6'd57: res = 32'hfe2ce6e0;
      6'd58: res = 32'ha3014314;  6'd59: res = 32'h4e0811a1;
      6'd60: res = 32'hf7537e82;  6'd61: res = 32'hbd3af235;
      6'd62: res = 32'h2ad7d2bb;  default: res = 32'heb86d391;
    endcase
    return res;
  endfunction

endpackage

[hdl/md5_round.sv]
// One MD5 round: the shared datapath stepped once per cycle by the sequencer.
module md5_round (
  input  md5_pkg::md5_words_t words_i,
  input  logic [31:0]         msg_i,
  input  logic [5:0]          rnd_i,
  output md5_pkg::md5_words_t words_o
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [31:0] rot;

  always_comb begin
    case (rnd_i[5:4])
      2'd0:    f = (words_i.b & words_i.c) | (~words_i.b & words_i.d);
      2'd1:    f = (words_i.d & words_i.b) | (~words_i.d & words_i.c);
      2'd2:    f = words_i.b ^ words_i.c ^ words_i.d;
      default: f = words_i.c ^ (words_i.b | ~words_i.d);
    endcase
  end

  assign sum      = words_i.a + f + md5_k(rnd_i) + msg_i;
  assign rot_wide = {sum, sum} << md5_shift(rnd_i);
  assign rot      = rot_wide[63:32];

  assign words_o.a = words_i.d;
  assign words_o.b = words_i.b + rot;
  assign words_o.c = words_i.b;
  assign words_o.d = words_i.c;

endmodule

[hdl/md5_message_digest_top.sv]
// MD5 digest engine top level: word intake, padding sequencer and round loop.
//
// Usage: stream a message as 32-bit words on the input channel, first byte in
// bits 7:0. Every word but the last carries four bytes. The word with
// last_word set carries 0 to 4 bytes (counts above four act as four); an empty
// tail word with count zero is allowed, and alone it yields the empty digest.
// A transfer happens on a rising edge with valid high and stall low.
// Timing: the sixteenth word of a block starts the shared round unit, which
// does one round per cycle: 64 rounds, then one chaining update. After the
// last word the sequencer writes one padding or length word per cycle and
// runs one or two more blocks before the digest is loaded.
// in_stall_o is high in every state but idle: while padding, running rounds,
// updating the chain and loading the digest.
// The digest sits in an output register; the engine takes the next message
// while it waits, and holds before loading another digest until the slot is
// free. A stalled receiver thus only delays the following message's end.
// Reset: chaining words return to the initial values, the length count and
// word pointer clear, and no result is pending.
module md5_message_digest_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  md5_pkg::md5_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output md5_pkg::md5_out_t out_data_o
);
  import md5_pkg::*;

  md5_state_e  state_q, state_d;
  md5_words_t  chain_q, chain_d;
  md5_words_t  rw_q, rw_d;
  md5_words_t  rw_next;
  logic [63:0] bitlen_q, bitlen_d;
  logic [3:0]  pos_q, pos_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        fin_q, fin_d;        // padding of the current message under way
  logic        pad80_q, pad80_d;    // pad byte still owed as a word of its own
  logic        len_done_q, len_done_d;  // low length word written to the block
  logic        out_valid_q, out_valid_d;
  md5_out_t    out_data_q, out_data_d;

  logic [31:0] buf_q [16];
  logic        push_en;
  logic [31:0] push_word;
  logic        in_xfer;
  logic [2:0]  n_eff;
  logic [31:0] tail_word;
  logic [31:0] msg_word;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Clamp the byte count and build the padded tail word.
  assign n_eff = (in_data_i.byte_count > 3'd4) ? 3'd4 : in_data_i.byte_count;

  always_comb begin
    case (n_eff)
      3'd0:    tail_word = {24'h0, PAD_BYTE};
      3'd1:    tail_word = {16'h0, PAD_BYTE, in_data_i.data_word[7:0]};
      3'd2:    tail_word = {8'h0, PAD_BYTE, in_data_i.data_word[15:0]};
      3'd3:    tail_word = {PAD_BYTE, in_data_i.data_word[23:0]};
      default: tail_word = in_data_i.data_word;
    endcase
  end

  assign msg_word = buf_q[md5_msg_index(rnd_q)];

  md5_round u_round (
    .words_i (rw_q),
    .msg_i   (msg_word),
    .rnd_i   (rnd_q),
    .words_o (rw_next)
  );

  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    rw_d        = rw_q;
    bitlen_d    = bitlen_q;
    rnd_d       = rnd_q;
    fin_d       = fin_q;
    pad80_d     = pad80_q;
    len_done_d  = len_done_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    push_en     = 1'b0;
    push_word   = in_data_i.data_word;

    // Drop the result once the receiver takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          push_en = 1'b1;
          if (in_data_i.last_word) begin
            push_word = tail_word;
            bitlen_d  = bitlen_q + {58'h0, n_eff, 3'b000};
            fin_d     = 1'b1;
            pad80_d   = (n_eff == 3'd4);
          end else begin
            bitlen_d = bitlen_q + 64'd32;
          end
          if (pos_q == 4'd15) begin
            rw_d    = chain_q;
            state_d = ST_ROUND;
          end else if (in_data_i.last_word) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        pad80_d = 1'b0;
        if (pad80_q) begin
          push_word = {24'h0, PAD_BYTE};
        end else if (pos_q == 4'd14) begin
          push_word  = bitlen_q[31:0];
          len_done_d = 1'b1;
        end else if (pos_q == 4'd15 && len_done_q) begin
          push_word = bitlen_q[63:32];
        end else begin
          push_word = '0;
        end
        if (pos_q == 4'd15) begin
          rw_d    = chain_q;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rw_d  = rw_next;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        chain_d.a = chain_q.a + rw_q.a;
        chain_d.b = chain_q.b + rw_q.b;
        chain_d.c = chain_q.c + rw_q.c;
        chain_d.d = chain_q.d + rw_q.d;
        if (len_done_q) begin
          state_d = ST_EMIT;
        end else if (fin_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // Hold until the output slot is free, then load and restart.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_data_d.digest_low  = {chain_q.b, chain_q.a};
          out_data_d.digest_high = {chain_q.d, chain_q.c};
          chain_d                = MD5_IV;
          bitlen_d               = '0;
          fin_d                  = 1'b0;
          len_done_d             = 1'b0;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign pos_d = push_en ? pos_q + 4'd1 : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= MD5_IV;
      rw_q        <= '0;
      bitlen_q    <= '0;
      pos_q       <= '0;
      rnd_q       <= '0;
      fin_q       <= 1'b0;
      pad80_q     <= 1'b0;
      len_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      rw_q        <= rw_d;
      bitlen_q    <= bitlen_d;
      pos_q       <= pos_d;
      rnd_q       <= rnd_d;
      fin_q       <= fin_d;
      pad80_q     <= pad80_d;
      len_done_q  <= len_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (push_en) begin
      buf_q[pos_q] <= push_word;
    end
  end

  // The block is full whenever rounds run or the chain is updated.
  a_pos_zero_in_rounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND || state_q == ST_FINAL) |-> (pos_q == 4'd0))
    else $error("word pointer not at block start during compression");

  // The round counter only moves while rounds run.
  a_rnd_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rnd_q != 6'd0) |-> (state_q == ST_ROUND))
    else $error("round counter nonzero outside round loop");

  // A digest load leaves a fresh message context behind.
  a_emit_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && state_d == ST_IDLE) |=>
      (bitlen_q == 64'd0 && pos_q == 4'd0 && !fin_q && out_valid_q))
    else $error("message context not restarted after digest");

endmodule

[tb/tb_md5_message_digest_top.sv]
// Testbench for the MD5 digest engine: directed tails, padding spills, random message streams.
module tb_md5_message_digest_top;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::md5_in_t;
  import md5_pkg::md5_out_t;

  typedef logic [31:0] word_t;

  // Additive round constants, one per round.
  localparam word_t ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts: row is the round group, column is round mod 4.
  localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // Number of cycles to let pass once the last digest is in, to watch for
  // stray digests.
  localparam int DRAIN_CYCLES = 200;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  md5_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  md5_out_t out_data_o;

  md5_message_digest_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Running hash of the message in flight, as the engine should hold it.
  word_t       hash_state [4];
  word_t       msg_block [16];
  logic [63:0] msg_bits;
  int unsigned fill_pos;

  // Digests owed by the engine, oldest first.
  md5_out_t    pending_digests [$];
  int unsigned mismatch_count = 0;

  // Idle pressure, in percent, on the two channels.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  function automatic word_t rotl(input word_t x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // Run the 64 rounds over the gathered block and fold into the hash.
  function automatic void md5_compress();
    word_t a, b, c, d, f, sum, nb;
    int    g;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      sum = a + f + ROUND_K[i] + msg_block[g];
      nb  = b + rotl(sum, ROT_AMT[(i / 16) * 4 + i % 4]);
      a = d;
      d = c;
      c = b;
      b = nb;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
  endfunction

  function automatic void md5_absorb_word(input word_t w);
    msg_block[fill_pos] = w;
    fill_pos = (fill_pos + 1) % 16;
    if (fill_pos == 0) md5_compress();
  endfunction

  function automatic void md5_restart();
    hash_state[0] = md5_pkg::MD5_IV.a;
    hash_state[1] = md5_pkg::MD5_IV.b;
    hash_state[2] = md5_pkg::MD5_IV.c;
    hash_state[3] = md5_pkg::MD5_IV.d;
    msg_bits = '0;
    fill_pos = 0;
  endfunction

  // Advance the running hash by one accepted word; on the tail word, pad,
  // append the length, and queue the digest the engine owes.
  function automatic void md5_take_word(input md5_in_t item);
    int unsigned n;
    word_t       mask;
    md5_out_t    digest;
    n = (item.byte_count > 3'd4) ? 4 : item.byte_count;
    if (!item.last_word) begin
      // short counts mid-message are ignored: all four bytes count
      md5_absorb_word(item.data_word);
      msg_bits += 64'd32;
      return;
    end
    msg_bits += 64'(8 * n);
    if (n == 4) begin
      md5_absorb_word(item.data_word);
      md5_absorb_word(word_t'(md5_pkg::PAD_BYTE));
    end else begin
      // drop the bytes past the count, put the pad byte right after them
      mask = (n == 0) ? '0 : (word_t'(1) << (8 * n)) - word_t'(1);
      md5_absorb_word((item.data_word & mask) | (word_t'(md5_pkg::PAD_BYTE) << (8 * n)));
    end
    while (fill_pos != 14) md5_absorb_word('0);
    md5_absorb_word(msg_bits[31:0]);
    md5_absorb_word(msg_bits[63:32]);
    digest.digest_low  = {hash_state[1], hash_state[0]};
    digest.digest_high = {hash_state[3], hash_state[2]};
    pending_digests.push_back(digest);
    md5_restart();
  endfunction

  // Present one word and hold it until the engine takes it. Idle cycles go in
  // front of the word only, so valid never drops while a word is stalled.
  task automatic send_word(input md5_in_t item);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    // stall is sampled before this edge's updates land, so the check is race-free
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    md5_take_word(item);
  endtask

  // Receive side: check each digest transfer against the oldest one owed,
  // then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    md5_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digests.size() == 0) begin
        mismatch_count++;
        $display("%0t: digest with none expected: low %h high %h", $time,
                 out_data_o.digest_low, out_data_o.digest_high);
      end else begin
        want = pending_digests.pop_front();
        if (out_data_o.digest_low !== want.digest_low) begin
          mismatch_count++;
          $display("%0t: digest_low mismatch: expected %h, actual %h", $time,
                   want.digest_low, out_data_o.digest_low);
        end
        if (out_data_o.digest_high !== want.digest_high) begin
          mismatch_count++;
          $display("%0t: digest_high mismatch: expected %h, actual %h", $time,
                   want.digest_high, out_data_o.digest_high);
        end
      end
    end
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Tail word with every byte count: empty message, 1..4 bytes with junk in
  // the unused lanes, and counts above four that must act as four.
  task automatic test_tail_byte_counts();
    md5_in_t item;
    item.last_word  = 1'b1;
    item.data_word  = $urandom;
    item.byte_count = 3'd0;
    send_word(item);
    for (int n = 1; n <= 7; n++) begin
      item.data_word  = (n % 2 == 1) ? 32'hffff_ffff : $urandom;
      item.byte_count = 3'(n);
      send_word(item);
    end
  endtask

  // Short counts on words that are not the tail must be ignored.
  task automatic test_short_count_mid_message();
    md5_in_t item;
    item.last_word  = 1'b0;
    item.data_word  = 32'h0000_0000;
    item.byte_count = 3'd0;
    send_word(item);
    item.data_word  = 32'hffff_ffff;
    item.byte_count = 3'd2;
    send_word(item);
    item.last_word  = 1'b1;
    item.data_word  = $urandom;
    item.byte_count = 3'd4;
    send_word(item);
  endtask

  // Fourteen full words: pad byte and length no longer fit, so the engine
  // must run a second padding block.
  task automatic test_two_block_padding();
    md5_in_t item;
    item.byte_count = 3'd4;
    item.last_word  = 1'b0;
    for (int w = 0; w < 13; w++) begin
      item.data_word = (w % 2 == 0) ? 32'h0000_0000 : 32'hffff_ffff;
      send_word(item);
    end
    item.last_word = 1'b1;
    item.data_word = $urandom;
    send_word(item);
  endtask

  // Stream well-formed messages of random length and content; one in ten
  // body words carries a stray byte count as noise.
  task automatic test_random_messages(input int unsigned word_budget);
    int unsigned sent;
    int unsigned msg_len;
    int unsigned pick;
    md5_in_t     item;
    sent = 0;
    while (sent < word_budget) begin
      pick = $urandom_range(99);
      if (pick < 60)      msg_len = $urandom_range(0, 6);
      else if (pick < 85) msg_len = $urandom_range(7, 17);
      else if (pick < 95) msg_len = $urandom_range(18, 40);
      else                msg_len = $urandom_range(60, 80);
      item.last_word = 1'b0;
      for (int w = 0; w < msg_len; w++) begin
        item.data_word  = $urandom;
        item.byte_count = ($urandom_range(99) < 10) ? 3'($urandom_range(0, 7)) : 3'd4;
        send_word(item);
      end
      item.last_word  = 1'b1;
      item.data_word  = $urandom;
      item.byte_count = 3'($urandom_range(0, 7));
      send_word(item);
      sent += msg_len + 1;
    end
  endtask

  initial begin
    md5_restart();
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    // hold reset, release on an edge
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_tail_byte_counts();
    test_short_count_mid_message();
    test_two_block_padding();

    // sweep the idle pressure on both channels
    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random_messages(330);
    send_idle_pct = 58; recv_stall_pct = 0;
    test_random_messages(330);
    send_idle_pct = 0;  recv_stall_pct = 58;
    test_random_messages(330);
    send_idle_pct = 29; recv_stall_pct = 29;
    test_random_messages(330);

    in_valid_i <= 1'b0;
    // drain: wait for every owed digest, then watch for strays
    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_digests.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest legal run of this stimulus.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
